// ===== rtl/core/tbk_pkg.sv =====
// tbk_pkg: shared constants, codes and control structs of the two-budget knapsack counter
// used by tbk_ctrl, tbk_dp and two_budget_knapsack_count; no dependencies
`timescale 1ns / 1ps

package tbk_pkg;

   localparam int BUDGET_MAX_DEFAULT  = 127;
   localparam int COUNT_WIDTH_DEFAULT = 8;

   localparam int COST_WIDTH      = 8;
   localparam int BUDGET_IN_WIDTH = 7;
   localparam int OUT_WIDTH       = 8;
   localparam int OUT_MAX         = 255;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic walk_start;
      logic walk_clear;
      logic query_read;
      logic load_rsp;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic walk_done;
   } status_type;

endpackage

// ===== rtl/core/tbk_ctrl.sv =====
// tbk_ctrl: controller state machine of the two-budget knapsack counter
// depends on tbk_pkg; drives tbk_dp through tbk_pkg::cmd_type
`timescale 1ns / 1ps

module tbk_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_kind,
   input  tbk_pkg::status_type status,
   output tbk_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_strobe_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      cmd.walk_start = (state_ff == ST_INIT) || (accept && req_kind == tbk_pkg::KIND_ADD);
      cmd.walk_clear = (state_ff == ST_INIT);
      cmd.query_read = accept && req_kind == tbk_pkg::KIND_QUERY;
      cmd.load_rsp   = (state_ff == ST_QUERY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               state_ff <= ST_CLEAR;
            end
            ST_CLEAR, ST_UPDATE: begin
               if (status.walk_done) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  busy_ff <= 1'b1;
                  if (req_kind == tbk_pkg::KIND_QUERY) begin
                     state_ff <= ST_QUERY;
                  end else begin
                     state_ff <= ST_UPDATE;
                  end
               end
            end
            ST_QUERY: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
               busy_ff       <= 1'b0;
            end
            default: begin
               state_ff <= ST_INIT;
               busy_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

// ===== rtl/core/tbk_dp.sv =====
// tbk_dp: datapath of the two-budget knapsack counter: budget walk counters,
// count table memory and the max/increment update stage; depends on tbk_pkg
`timescale 1ns / 1ps

module tbk_dp #(
   parameter int BUDGET_MAX  = tbk_pkg::BUDGET_MAX_DEFAULT,
   parameter int COUNT_WIDTH = tbk_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tbk_pkg::cmd_type                     cmd,
   output tbk_pkg::status_type                  status,
   input  logic [tbk_pkg::COST_WIDTH-1:0]       req_red_cost,
   input  logic [tbk_pkg::COST_WIDTH-1:0]       req_blue_cost,
   input  logic [tbk_pkg::BUDGET_IN_WIDTH-1:0]  req_red_budget,
   input  logic [tbk_pkg::BUDGET_IN_WIDTH-1:0]  req_blue_budget,
   output logic [tbk_pkg::OUT_WIDTH-1:0]        rsp_best_count
);

   localparam int BW    = $clog2(BUDGET_MAX + 1);
   localparam int AW    = 2 * BW;
   localparam int DEPTH = 1 << AW;
   localparam logic [BW-1:0] TOP = BW'(BUDGET_MAX);

   logic [COUNT_WIDTH-1:0] table_mem [0:DEPTH-1];

   // walk state
   logic [BW-1:0] x_ff, y_ff;
   logic [BW-1:0] lo_x_ff, lo_y_ff;
   logic          clr_ff;
   logic          walk_ff;

   // update stage
   logic                   s1_valid_ff;
   logic                   s1_clr_ff;
   logic [AW-1:0]          s1_addr_ff;
   logic [COUNT_WIDTH-1:0] rd_cur_ff;
   logic [COUNT_WIDTH-1:0] rd_src_ff;
   logic [tbk_pkg::OUT_WIDTH-1:0] rsp_best_count_ff;

   logic                   fits;
   logic [BW-1:0]          qx, qy;
   logic [AW-1:0]          addr_a, addr_b;
   logic [COUNT_WIDTH-1:0] src_inc;
   logic [COUNT_WIDTH-1:0] wdata;

   assign fits = (32'(req_red_cost) <= 32'(BUDGET_MAX))
              && (32'(req_blue_cost) <= 32'(BUDGET_MAX));

   assign qx = (32'(req_red_budget) > 32'(BUDGET_MAX)) ? TOP : BW'(req_red_budget);
   assign qy = (32'(req_blue_budget) > 32'(BUDGET_MAX)) ? TOP : BW'(req_blue_budget);

   assign addr_a = walk_ff ? {x_ff, y_ff} : {qx, qy};
   assign addr_b = {x_ff - lo_x_ff, y_ff - lo_y_ff};

   assign src_inc = (rd_src_ff == '1) ? rd_src_ff : COUNT_WIDTH'(rd_src_ff + 1'b1);
   assign wdata   = s1_clr_ff ? '0 : ((src_inc > rd_cur_ff) ? src_inc : rd_cur_ff);

   // walk counters, high to low in both budgets
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= walk_ff;
         if (cmd.walk_start) begin
            x_ff <= TOP;
            y_ff <= TOP;
            if (cmd.walk_clear) begin
               lo_x_ff <= '0;
               lo_y_ff <= '0;
               clr_ff  <= 1'b1;
               walk_ff <= 1'b1;
            end else begin
               lo_x_ff <= BW'(req_red_cost);
               lo_y_ff <= BW'(req_blue_cost);
               clr_ff  <= 1'b0;
               walk_ff <= fits;
            end
         end else if (walk_ff) begin
            if (y_ff == lo_y_ff) begin
               y_ff <= TOP;
               if (x_ff == lo_x_ff) begin
                  walk_ff <= 1'b0;
               end else begin
                  x_ff <= x_ff - 1'b1;
               end
            end else begin
               y_ff <= y_ff - 1'b1;
            end
         end
      end
   end

   // count table: two registered reads, one write
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         table_mem[s1_addr_ff] <= wdata;
      end
      if (walk_ff || cmd.query_read) begin
         rd_cur_ff <= table_mem[addr_a];
      end
      if (walk_ff) begin
         rd_src_ff  <= table_mem[addr_b];
         s1_addr_ff <= {x_ff, y_ff};
         s1_clr_ff  <= clr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_best_count_ff <= (32'(rd_cur_ff) > 32'(tbk_pkg::OUT_MAX))
                            ? tbk_pkg::OUT_WIDTH'(tbk_pkg::OUT_MAX)
                            : tbk_pkg::OUT_WIDTH'(rd_cur_ff);
      end
   end

   assign status.walk_done = !walk_ff && !s1_valid_ff;
   assign rsp_best_count   = rsp_best_count_ff;

endmodule

// ===== rtl/core/two_budget_knapsack_count.sv =====
// two_budget_knapsack_count: top level of the two-dimensional 0/1 knapsack counter
// depends on tbk_pkg, tbk_ctrl and tbk_dp
`timescale 1ns / 1ps
//
// usage
// - a transaction is taken at a rising edge with start high and busy low
// - req_kind add: req_red_cost/req_blue_cost fold one item into the count table;
//   no result; busy while it walks the (BUDGET_MAX-red+1)*(BUDGET_MAX-blue+1) entries,
//   one table entry per cycle, set by the single write port of the table memory;
//   an item with a cost above BUDGET_MAX leaves the table alone
// - req_kind query: req_red_budget/req_blue_budget (clamped to BUDGET_MAX) select
//   one entry, read into a register and then into the rsp_best_count register;
//   rsp_strobe is high for one cycle with rsp_best_count, saturated at 255
// - a new transaction may be taken in the cycle the result is shown
// - after reset the table is cleared to zero, one entry per cycle, with busy high
// - the receiver cannot stall; each result is valid for its strobe cycle only

module two_budget_knapsack_count #(
   parameter int BUDGET_MAX  = tbk_pkg::BUDGET_MAX_DEFAULT,
   parameter int COUNT_WIDTH = tbk_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic [tbk_pkg::COST_WIDTH-1:0]       req_red_cost,
   input  logic [tbk_pkg::COST_WIDTH-1:0]       req_blue_cost,
   input  logic [tbk_pkg::BUDGET_IN_WIDTH-1:0]  req_red_budget,
   input  logic [tbk_pkg::BUDGET_IN_WIDTH-1:0]  req_blue_budget,
   output logic                                 rsp_strobe,
   output logic [tbk_pkg::OUT_WIDTH-1:0]        rsp_best_count
);

   tbk_pkg::cmd_type    cmd;
   tbk_pkg::status_type status;

   tbk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_kind),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   tbk_dp #(
      .BUDGET_MAX  (BUDGET_MAX),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_red_cost    (req_red_cost),
      .req_blue_cost   (req_blue_cost),
      .req_red_budget  (req_red_budget),
      .req_blue_budget (req_blue_budget),
      .rsp_best_count  (rsp_best_count)
   );

   // query transaction gives a strobe
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == tbk_pkg::KIND_QUERY) |-> ##2 rsp_strobe)
      else $error("query without result");

   // every transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after transaction");

   // result strobes never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back result strobes");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for two_budget_knapsack_count. A directed table
// and random add and query transactions are checked against typed expected values
// or an in-bench count table. Depends on tbk_pkg and two_budget_knapsack_count.

module tb_top;

   localparam int BMAX      = tbk_pkg::BUDGET_MAX_DEFAULT;
   localparam int CW        = tbk_pkg::COUNT_WIDTH_DEFAULT;
   localparam int COUNT_SAT = (1 << CW) - 1;
   localparam int N_RANDOM  = 75;
   localparam int N_ROWS    = 25;

   typedef struct packed {
      logic                                kind;
      logic [tbk_pkg::COST_WIDTH-1:0]      red_cost;
      logic [tbk_pkg::COST_WIDTH-1:0]      blue_cost;
      logic [tbk_pkg::BUDGET_IN_WIDTH-1:0] red_budget;
      logic [tbk_pkg::BUDGET_IN_WIDTH-1:0] blue_budget;
   } txn_type;

   typedef struct packed {
      txn_type                       txn;
      logic                          known;
      logic [tbk_pkg::OUT_WIDTH-1:0] count;
   } dir_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic                                req_kind = tbk_pkg::KIND_ADD;
   logic [tbk_pkg::COST_WIDTH-1:0]      req_red_cost = '0;
   logic [tbk_pkg::COST_WIDTH-1:0]      req_blue_cost = '0;
   logic [tbk_pkg::BUDGET_IN_WIDTH-1:0] req_red_budget = '0;
   logic [tbk_pkg::BUDGET_IN_WIDTH-1:0] req_blue_budget = '0;
   logic                                rsp_strobe;
   logic [tbk_pkg::OUT_WIDTH-1:0]       rsp_best_count;

   logic [CW-1:0]                 count_table [0:BMAX][0:BMAX];
   logic [tbk_pkg::OUT_WIDTH-1:0] pending_counts [$];
   logic [tbk_pkg::OUT_WIDTH-1:0] wanted_count;

   int mismatch_count = 0;
   int add_count      = 0;
   int oversize_count = 0;
   int query_count    = 0;
   int checked_count  = 0;
   int top_count      = 0;
   int idle_pct [3]   = '{8, 57, 0};

   // expected value is typed in only where it reads off directly
   dir_row_type directed_rows [0:N_ROWS-1] = '{
      '{'{tbk_pkg::KIND_QUERY, 8'hff, 8'h00, 7'd0,   7'd0  }, 1'b1, 8'd0},  // cleared table
      '{'{tbk_pkg::KIND_QUERY, 8'h00, 8'hff, 7'd127, 7'd127}, 1'b1, 8'd0},
      '{'{tbk_pkg::KIND_ADD,   8'd128, 8'd0, 7'd127, 7'd0  }, 1'b0, 8'd0},  // costly items
      '{'{tbk_pkg::KIND_ADD,   8'd255, 8'd255, 7'd0, 7'd127}, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_ADD,   8'd0, 8'd200, 7'h55,  7'h2a }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd127, 7'd127}, 1'b1, 8'd0},
      '{'{tbk_pkg::KIND_ADD,   8'd0,  8'd0,  7'd0,   7'd0  }, 1'b0, 8'd0},  // zero costs
      '{'{tbk_pkg::KIND_QUERY, 8'haa, 8'h55, 7'd0,   7'd0  }, 1'b1, 8'd1},
      '{'{tbk_pkg::KIND_QUERY, 8'h55, 8'haa, 7'd127, 7'd127}, 1'b1, 8'd1},
      '{'{tbk_pkg::KIND_ADD,   8'd127, 8'd127, 7'd0, 7'd0  }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd127, 7'd127}, 1'b1, 8'd2},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd126, 7'd127}, 1'b1, 8'd1},
      '{'{tbk_pkg::KIND_ADD,   8'd127, 8'd0, 7'h2a,  7'h55 }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_ADD,   8'd0, 8'd127, 7'h7f,  7'h00 }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd127, 7'd127}, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd0,   7'd127}, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd127, 7'd0  }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_ADD,   8'd64, 8'd64, 7'd0,   7'd0  }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_ADD,   8'd63, 8'd63, 7'd0,   7'd0  }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd127, 7'd127}, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd63,  7'd63 }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_ADD,   8'd0,  8'd0,  7'd127, 7'd127}, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd127, 7'd127}, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'h2a,  7'h55 }, 1'b0, 8'd0},
      '{'{tbk_pkg::KIND_QUERY, 8'd0,  8'd0,  7'd64,  7'd64 }, 1'b0, 8'd0}
   };

   two_budget_knapsack_count i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_red_cost    (req_red_cost),
      .req_blue_cost   (req_blue_cost),
      .req_red_budget  (req_red_budget),
      .req_blue_budget (req_blue_budget),
      .rsp_strobe      (rsp_strobe),
      .rsp_best_count  (rsp_best_count)
   );

   always #5 clock = ~clock;

   initial begin
      #100_000_000;
      $display("FAILURE");
      $finish;
   end

   // fold one item into the count table, both budgets walked high to low
   function automatic void fold_item(logic [tbk_pkg::COST_WIDTH-1:0] rc,
                                     logic [tbk_pkg::COST_WIDTH-1:0] bc);
      int r;
      int b;
      logic [CW-1:0] cand;
      r = int'(rc);
      b = int'(bc);
      if (r > BMAX || b > BMAX) return;
      for (int x = BMAX; x >= r; x--) begin
         for (int y = BMAX; y >= b; y--) begin
            cand = count_table[x - r][y - b];
            if (cand != COUNT_SAT) cand = cand + 1'b1;
            if (cand > count_table[x][y]) count_table[x][y] = cand;
         end
      end
   endfunction

   function automatic logic [tbk_pkg::OUT_WIDTH-1:0] best_within(
         logic [tbk_pkg::BUDGET_IN_WIDTH-1:0] rb,
         logic [tbk_pkg::BUDGET_IN_WIDTH-1:0] bb);
      int r;
      int b;
      int v;
      r = (int'(rb) > BMAX) ? BMAX : int'(rb);
      b = (int'(bb) > BMAX) ? BMAX : int'(bb);
      v = int'(count_table[r][b]);
      if (v > tbk_pkg::OUT_MAX) v = tbk_pkg::OUT_MAX;
      return v[tbk_pkg::OUT_WIDTH-1:0];
   endfunction

   function automatic txn_type random_txn();
      txn_type t;
      int pick;
      t.red_cost    = tbk_pkg::COST_WIDTH'($urandom_range(255));
      t.blue_cost   = tbk_pkg::COST_WIDTH'($urandom_range(255));
      t.red_budget  = tbk_pkg::BUDGET_IN_WIDTH'($urandom_range(127));
      t.blue_budget = tbk_pkg::BUDGET_IN_WIDTH'($urandom_range(127));
      if ($urandom_range(99) < 55) begin
         t.kind = tbk_pkg::KIND_QUERY;
         if ($urandom_range(99) < 30) begin
            t.red_budget  = tbk_pkg::BUDGET_IN_WIDTH'(BMAX);
            t.blue_budget = tbk_pkg::BUDGET_IN_WIDTH'(BMAX);
         end
      end else begin
         t.kind = tbk_pkg::KIND_ADD;
         pick   = int'($urandom_range(99));
         // small costs touch most of the table, so keep them rare
         if (pick < 10) begin
            t.red_cost  = tbk_pkg::COST_WIDTH'($urandom_range(31));
            t.blue_cost = tbk_pkg::COST_WIDTH'($urandom_range(31));
         end else if (pick < 22) begin
            if ($urandom_range(1)) t.red_cost  = tbk_pkg::COST_WIDTH'($urandom_range(255, 128));
            else                   t.blue_cost = tbk_pkg::COST_WIDTH'($urandom_range(255, 128));
         end else begin
            t.red_cost  = tbk_pkg::COST_WIDTH'($urandom_range(127, 24));
            t.blue_cost = tbk_pkg::COST_WIDTH'($urandom_range(127, 24));
         end
      end
      return t;
   endfunction

   task automatic report_mismatch(string what, logic [tbk_pkg::OUT_WIDTH-1:0] want,
                                  logic [tbk_pkg::OUT_WIDTH-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic idle_gap(int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   // drive one transaction and hold it until the block takes it
   task automatic send(txn_type t, logic known, logic [tbk_pkg::OUT_WIDTH-1:0] typed);
      req_kind        <= t.kind;
      req_red_cost    <= t.red_cost;
      req_blue_cost   <= t.blue_cost;
      req_red_budget  <= t.red_budget;
      req_blue_budget <= t.blue_budget;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (t.kind == tbk_pkg::KIND_QUERY) begin
         pending_counts = {pending_counts,
                           (known ? typed : best_within(t.red_budget, t.blue_budget))};
         query_count++;
      end else begin
         fold_item(t.red_cost, t.blue_cost);
         add_count++;
         if (t.red_cost > BMAX || t.blue_cost > BMAX) oversize_count++;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_counts.size() != 0 || busy !== 1'b0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("result with no query pending", '0, rsp_best_count);
         end else begin
            wanted_count = pending_counts.pop_front();
            checked_count++;
            if (int'(rsp_best_count) > top_count) top_count = int'(rsp_best_count);
            if (rsp_best_count !== wanted_count)
               report_mismatch("best_count", wanted_count, rsp_best_count);
         end
      end
   end

   initial begin
      for (int x = 0; x <= BMAX; x++)
         for (int y = 0; y <= BMAX; y++)
            count_table[x][y] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_ROWS; i++) begin
         idle_gap(idle_pct[0]);
         send(directed_rows[i].txn, directed_rows[i].known, directed_rows[i].count);
      end

      for (int ph = 0; ph < 3; ph++) begin
         drain();
         for (int i = 0; i < (N_RANDOM + 2) / 3; i++) begin
            idle_gap(idle_pct[ph]);
            send(random_txn(), 1'b0, '0);
         end
      end

      drain();
      repeat (10) @(posedge clock);

      $display("covered %0d adds (%0d over budget range) and %0d queries",
               add_count, oversize_count, query_count);
      $display("checked %0d results, largest count seen %0d", checked_count, top_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tbk_pkg.sv
rtl/core/tbk_ctrl.sv
rtl/core/tbk_dp.sv
rtl/core/two_budget_knapsack_count.sv
verif/tb_top.sv
